### src/fdsu_pkg.sv
package fdsu_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int SP_W        = $clog2(STACK_DEPTH + 1);
	localparam int CELL_W      = 32;
	localparam int OP_W        = 4;
	localparam int STATUS_W    = 2;
	localparam int DEPTH_W     = 7;

	typedef logic signed [CELL_W-1:0] cell_t;
	typedef logic [SP_W-1:0]          sp_t;
	typedef logic [ADDR_W-1:0]        addr_t;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH     = 4'd0,
		OP_DROP     = 4'd1,
		OP_DUP      = 4'd2,
		OP_PICK     = 4'd3,
		OP_SWAP     = 4'd4,
		OP_ROT      = 4'd5,
		OP_PRINT    = 4'd6,
		OP_SP_FETCH = 4'd7,
		OP_SP_STORE = 4'd8,
		OP_RP_FETCH = 4'd9,
		OP_RP_STORE = 4'd10
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_UNDER  = 2'd1,
		ST_OVER   = 2'd2,
		ST_BADPTR = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ADDR_SP,
		ADDR_M1,
		ADDR_M2,
		ADDR_M3,
		ADDR_PICK
	} addr_sel_t;

	typedef enum logic [2:0] {
		WD_LIT,
		WD_SP,
		WD_RP,
		WD_RD,
		WD_OPA,
		WD_OPB
	} wdata_sel_t;

	typedef enum logic [1:0] {
		SP_HOLD,
		SP_INC,
		SP_DEC,
		SP_LOAD
	} sp_op_t;

	typedef struct packed {
		logic       req_load;
		logic       rd_en;
		addr_sel_t  rd_sel;
		logic       wr_en;
		addr_sel_t  wr_sel;
		wdata_sel_t wr_data;
		sp_op_t     sp_op;
		logic       rp_load;
		logic       opa_load;
		logic       opb_load;
		logic       done;
		status_t    status;
		logic       print;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    empty;
		logic    lt2;
		logic    lt3;
		logic    pick_bad;
		logic    sp_bad;
		logic    out_free;
	} stat_t;

endpackage

### src/fdsu_req_if.sv
interface fdsu_req_if;
	import fdsu_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   req_type;
	cell_t             literal;

	modport source (output valid, output req_type, output literal, input ready);
	modport sink (input valid, input req_type, input literal, output ready);
endinterface

### src/fdsu_rsp_if.sv
interface fdsu_rsp_if;
	import fdsu_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                print_valid;
	cell_t               print_value;
	logic [DEPTH_W-1:0]  depth;

	modport source (output valid, output status, output print_valid, output print_value,
		output depth, input ready);
	modport sink (input valid, input status, input print_valid, input print_value,
		input depth, output ready);
endinterface

### src/fdsu_ram.sv
module fdsu_ram #(
	parameter int  WIDTH = 32,
	parameter int  DEPTH = 64,
	localparam int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/fdsu_ctrl.sv
module fdsu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  fdsu_pkg::stat_t stat,
	output fdsu_pkg::cmd_t  cmd
);
	import fdsu_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_DUP_WR,
		S_PICK_CHK,
		S_PICK_WR,
		S_POP_WR,
		S_SWAP_RD2,
		S_SWAP_WR1,
		S_SWAP_WR2,
		S_ROT_RD2,
		S_ROT_RD3,
		S_ROT_WR1,
		S_ROT_WR2,
		S_ROT_WR3
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd         = '0;
		cmd.rd_sel  = ADDR_M1;
		cmd.wr_sel  = ADDR_SP;
		cmd.wr_data = WD_RD;
		cmd.sp_op   = SP_HOLD;
		cmd.status  = ST_OK;
		state_d     = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_START;
				end
			end
			S_START: begin
				if (stat.out_free) begin
					unique case (stat.op) inside
						OP_PUSH, OP_SP_FETCH, OP_RP_FETCH: begin
							cmd.done = 1'b1;
							state_d  = S_IDLE;
							if (stat.full) begin
								cmd.status = ST_OVER;
							end else begin
								cmd.wr_en  = 1'b1;
								cmd.wr_sel = ADDR_SP;
								cmd.sp_op  = SP_INC;
								if (stat.op == OP_PUSH) begin
									cmd.wr_data = WD_LIT;
								end else if (stat.op == OP_SP_FETCH) begin
									cmd.wr_data = WD_SP;
								end else begin
									cmd.wr_data = WD_RP;
								end
							end
						end
						OP_DUP, OP_PICK: begin
							if (stat.full || stat.empty) begin
								cmd.done   = 1'b1;
								cmd.status = stat.full ? ST_OVER : ST_UNDER;
								state_d    = S_IDLE;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = ADDR_M1;
								state_d    = (stat.op == OP_DUP) ? S_DUP_WR : S_PICK_CHK;
							end
						end
						OP_DROP, OP_PRINT, OP_SP_STORE, OP_RP_STORE: begin
							if (stat.empty) begin
								cmd.done   = 1'b1;
								cmd.status = ST_UNDER;
								state_d    = S_IDLE;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = ADDR_M1;
								state_d    = S_POP_WR;
							end
						end
						OP_SWAP: begin
							if (stat.lt2) begin
								cmd.done   = 1'b1;
								cmd.status = ST_UNDER;
								state_d    = S_IDLE;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = ADDR_M1;
								state_d    = S_SWAP_RD2;
							end
						end
						OP_ROT: begin
							if (stat.lt3) begin
								cmd.done   = 1'b1;
								cmd.status = ST_UNDER;
								state_d    = S_IDLE;
							end else begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = ADDR_M3;
								state_d    = S_ROT_RD2;
							end
						end
						default: begin
							cmd.done = 1'b1;
							state_d  = S_IDLE;
						end
					endcase
				end
			end
			S_DUP_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = ADDR_SP;
				cmd.wr_data = WD_RD;
				cmd.sp_op   = SP_INC;
				cmd.done    = 1'b1;
				state_d     = S_IDLE;
			end
			S_PICK_CHK: begin
				if (stat.pick_bad) begin
					cmd.done   = 1'b1;
					cmd.status = ST_UNDER;
					state_d    = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = ADDR_PICK;
					state_d    = S_PICK_WR;
				end
			end
			S_PICK_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = ADDR_M1;
				cmd.wr_data = WD_RD;
				cmd.done    = 1'b1;
				state_d     = S_IDLE;
			end
			S_POP_WR: begin
				cmd.done  = 1'b1;
				cmd.sp_op = SP_DEC;
				state_d   = S_IDLE;
				if (stat.op == OP_PRINT) begin
					cmd.print = 1'b1;
				end else if (stat.op == OP_SP_STORE) begin
					if (stat.sp_bad) begin
						cmd.status = ST_BADPTR;
					end else begin
						cmd.sp_op = SP_LOAD;
					end
				end else if (stat.op == OP_RP_STORE) begin
					cmd.rp_load = 1'b1;
				end
			end
			S_SWAP_RD2: begin
				cmd.opa_load = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = ADDR_M2;
				state_d      = S_SWAP_WR1;
			end
			S_SWAP_WR1: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = ADDR_M1;
				cmd.wr_data = WD_RD;
				state_d     = S_SWAP_WR2;
			end
			S_SWAP_WR2: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = ADDR_M2;
				cmd.wr_data = WD_OPA;
				cmd.done    = 1'b1;
				state_d     = S_IDLE;
			end
			S_ROT_RD2: begin
				cmd.opa_load = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = ADDR_M2;
				state_d      = S_ROT_RD3;
			end
			S_ROT_RD3: begin
				cmd.opb_load = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = ADDR_M1;
				state_d      = S_ROT_WR1;
			end
			S_ROT_WR1: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = ADDR_M2;
				cmd.wr_data = WD_RD;
				state_d     = S_ROT_WR2;
			end
			S_ROT_WR2: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = ADDR_M3;
				cmd.wr_data = WD_OPB;
				state_d     = S_ROT_WR3;
			end
			S_ROT_WR3: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = ADDR_M1;
				cmd.wr_data = WD_OPA;
				cmd.done    = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	ap_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.req_load |=> state_q == S_START)
		else $error("Accepted beat did not start an operation.");

	ap_done_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> state_q == S_IDLE)
		else $error("Controller did not return to idle after a result.");

endmodule

### src/fdsu_dpath.sv
module fdsu_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [fdsu_pkg::OP_W-1:0]      req_type,
	input  fdsu_pkg::cell_t                literal,
	input  fdsu_pkg::cmd_t                 cmd,
	output fdsu_pkg::stat_t                stat,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [fdsu_pkg::STATUS_W-1:0]  rsp_status,
	output logic                           rsp_print_valid,
	output fdsu_pkg::cell_t                rsp_print_value,
	output logic [fdsu_pkg::DEPTH_W-1:0]   rsp_depth
);
	import fdsu_pkg::*;

	opcode_t                op_q;
	cell_t                  lit_q;
	sp_t                    sp_q;
	sp_t                    sp_d;
	cell_t                  rp_q;
	cell_t                  opa_q;
	cell_t                  opb_q;
	logic [STACK_DEPTH-1:0] valid_q;
	logic                   rd_valid_q;
	logic [CELL_W-1:0]      ram_rdata;
	cell_t                  rd_word;
	cell_t                  wr_word;
	addr_t                  rd_addr;
	addr_t                  wr_addr;
	addr_t                  sp_m1;
	addr_t                  sp_m2;
	addr_t                  sp_m3;
	addr_t                  pick_addr;
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    out_status_q;
	logic                   out_print_valid_q;
	cell_t                  out_print_value_q;
	logic [DEPTH_W-1:0]     out_depth_q;

	assign rd_word   = rd_valid_q ? cell_t'(ram_rdata) : '0;
	assign sp_m1     = ADDR_W'(sp_q - SP_W'(1));
	assign sp_m2     = ADDR_W'(sp_q - SP_W'(2));
	assign sp_m3     = ADDR_W'(sp_q - SP_W'(3));
	assign pick_addr = ADDR_W'(CELL_W'(sp_q) - CELL_W'(2) - $unsigned(rd_word));

	always_comb begin
		case (cmd.rd_sel)
			ADDR_SP:   rd_addr = ADDR_W'(sp_q);
			ADDR_M1:   rd_addr = sp_m1;
			ADDR_M2:   rd_addr = sp_m2;
			ADDR_M3:   rd_addr = sp_m3;
			ADDR_PICK: rd_addr = pick_addr;
			default:   rd_addr = sp_m1;
		endcase
		case (cmd.wr_sel)
			ADDR_SP:   wr_addr = ADDR_W'(sp_q);
			ADDR_M1:   wr_addr = sp_m1;
			ADDR_M2:   wr_addr = sp_m2;
			ADDR_M3:   wr_addr = sp_m3;
			ADDR_PICK: wr_addr = pick_addr;
			default:   wr_addr = ADDR_W'(sp_q);
		endcase
		case (cmd.wr_data)
			WD_LIT:  wr_word = lit_q;
			WD_SP:   wr_word = cell_t'(CELL_W'(sp_q));
			WD_RP:   wr_word = rp_q;
			WD_RD:   wr_word = rd_word;
			WD_OPA:  wr_word = opa_q;
			WD_OPB:  wr_word = opb_q;
			default: wr_word = rd_word;
		endcase
		case (cmd.sp_op)
			SP_HOLD: sp_d = sp_q;
			SP_INC:  sp_d = sp_q + SP_W'(1);
			SP_DEC:  sp_d = sp_q - SP_W'(1);
			SP_LOAD: sp_d = SP_W'(rd_word);
			default: sp_d = sp_q;
		endcase
	end

	fdsu_ram #(
		.WIDTH(CELL_W),
		.DEPTH(STACK_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(wr_addr),
		.wdata(wr_word),
		.re   (cmd.rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_comb begin
		stat.op       = op_q;
		stat.full     = (sp_q >= SP_W'(STACK_DEPTH));
		stat.empty    = (sp_q == '0);
		stat.lt2      = (sp_q < SP_W'(2));
		stat.lt3      = (sp_q < SP_W'(3));
		stat.pick_bad = rd_word[CELL_W-1] ||
			($unsigned(rd_word) >= CELL_W'(sp_q) - CELL_W'(1));
		stat.sp_bad   = rd_word[CELL_W-1] || ($unsigned(rd_word) > CELL_W'(STACK_DEPTH));
		stat.out_free = !out_valid_q || rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			op_q  <= opcode_t'(req_type);
			lit_q <= literal;
		end
		if (cmd.opa_load) begin
			opa_q <= rd_word;
		end
		if (cmd.opb_load) begin
			opb_q <= rd_word;
		end
		if (cmd.done) begin
			out_status_q      <= cmd.status;
			out_print_valid_q <= cmd.print;
			out_print_value_q <= cmd.print ? rd_word : '0;
			out_depth_q       <= DEPTH_W'(sp_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			rp_q        <= '0;
			valid_q     <= '0;
			rd_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			sp_q <= sp_d;
			if (cmd.rp_load) begin
				rp_q <= rd_word;
			end
			if (cmd.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
			if (cmd.done) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp_status      = out_status_q;
	assign rsp_print_valid = out_print_valid_q;
	assign rsp_print_value = out_print_value_q;
	assign rsp_depth       = out_depth_q;

	ap_sp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("Stack pointer beyond the stack depth.");

	ap_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |-> stat.out_free)
		else $error("Result produced while the output register is still occupied.");

	ap_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en && cmd.rd_en |-> wr_addr != rd_addr)
		else $error("Read and write of the same stack entry in one cycle.");

	ap_depth_matches_sp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> rsp_valid && rsp_depth == DEPTH_W'(sp_q))
		else $error("Reported depth differs from the stack pointer.");

endmodule

### src/forth_data_stack_unit_top.sv
// Data stack unit with one request channel and one response channel.
// Each request beat carries an operation code and a literal; each one yields
// exactly one response beat with a status, an optional printed value and the
// stack depth after the operation.
// The stack cells live in a single-port-read, single-port-write RAM, and
// every operation is stepped through by a controller, one RAM access of each
// kind per cycle. Push, sp@, rp@, unknown codes and any check that fails in
// the first step end in that step; dup, drop, print, sp! and rp! read the top
// cell first, pick reads its index and then the picked cell, and swap and
// rot read their cells before writing them back. The response beat is valid
// in the cycle after the last step, and a new request is taken as soon as
// the controller is back in idle, even while that response is still waiting.
// If the receiver stalls, the next operation is held in its first step until
// the output register frees up; state is not touched before then.
// Reset clears the stack pointer, the return pointer and the per-entry valid
// flags, so every cell reads as zero until written; no clearing pass is run
// and the block accepts requests in the first cycle after reset.
module forth_data_stack_unit_top (
	input logic        clk,
	input logic        arst_n,
	fdsu_req_if.sink   req,
	fdsu_rsp_if.source rsp
);
	import fdsu_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	fdsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fdsu_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_type       (req.req_type),
		.literal        (req.literal),
		.cmd            (cmd),
		.stat           (stat),
		.rsp_valid      (rsp.valid),
		.rsp_ready      (rsp.ready),
		.rsp_status     (rsp.status),
		.rsp_print_valid(rsp.print_valid),
		.rsp_print_value(rsp.print_value),
		.rsp_depth      (rsp.depth)
	);

endmodule

### tb/sv/fdsu_stack_checker.sv
module fdsu_stack_checker (
	input logic  clk,
	input logic  arst_n,
	fdsu_req_if  req,
	fdsu_rsp_if  rsp,
	output int   mismatches,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import fdsu_pkg::*;

	typedef struct packed {
		status_t            status;
		logic               print_valid;
		cell_t              print_value;
		logic [DEPTH_W-1:0] depth;
	} stack_result_t;

	cell_t         cells [STACK_DEPTH];
	int            stack_ptr;
	cell_t         ret_ptr;
	stack_result_t expected_results [$];

	function automatic stack_result_t apply_stack_op(input logic [OP_W-1:0] code, input cell_t lit);
		stack_result_t r;
		cell_t         top;
		cell_t         tmp;
		longint        n;
		r.status      = ST_OK;
		r.print_valid = 1'b0;
		r.print_value = '0;
		case (code)
		OP_PUSH, OP_SP_FETCH, OP_RP_FETCH: begin
			if (stack_ptr >= STACK_DEPTH) begin
				r.status = ST_OVER;
			end else begin
				if (code == OP_PUSH)
					cells[stack_ptr] = lit;
				else if (code == OP_SP_FETCH)
					cells[stack_ptr] = cell_t'(stack_ptr);
				else
					cells[stack_ptr] = ret_ptr;
				stack_ptr++;
			end
		end
		OP_DUP: begin
			if (stack_ptr >= STACK_DEPTH) begin
				r.status = ST_OVER;
			end else if (stack_ptr == 0) begin
				r.status = ST_UNDER;
			end else begin
				cells[stack_ptr] = cells[stack_ptr - 1];
				stack_ptr++;
			end
		end
		OP_PICK: begin
			if (stack_ptr >= STACK_DEPTH) begin
				r.status = ST_OVER;
			end else if (stack_ptr == 0) begin
				r.status = ST_UNDER;
			end else begin
				n = cells[stack_ptr - 1];
				if (n < 0 || stack_ptr < n + 2)
					r.status = ST_UNDER;
				else
					cells[stack_ptr - 1] = cells[stack_ptr - 2 - int'(n)];
			end
		end
		OP_DROP, OP_PRINT, OP_SP_STORE, OP_RP_STORE: begin
			if (stack_ptr == 0) begin
				r.status = ST_UNDER;
			end else begin
				top = cells[stack_ptr - 1];
				stack_ptr--;
				if (code == OP_PRINT) begin
					r.print_valid = 1'b1;
					r.print_value = top;
				end else if (code == OP_SP_STORE) begin
					n = top;
					if (n < 0 || n > STACK_DEPTH)
						r.status = ST_BADPTR;
					else
						stack_ptr = int'(n);
				end else if (code == OP_RP_STORE) begin
					ret_ptr = top;
				end
			end
		end
		OP_SWAP: begin
			if (stack_ptr < 2) begin
				r.status = ST_UNDER;
			end else begin
				tmp = cells[stack_ptr - 2];
				cells[stack_ptr - 2] = cells[stack_ptr - 1];
				cells[stack_ptr - 1] = tmp;
			end
		end
		OP_ROT: begin
			if (stack_ptr < 3) begin
				r.status = ST_UNDER;
			end else begin
				tmp = cells[stack_ptr - 3];
				cells[stack_ptr - 3] = cells[stack_ptr - 2];
				cells[stack_ptr - 2] = cells[stack_ptr - 1];
				cells[stack_ptr - 1] = tmp;
			end
		end
		default: begin
		end
		endcase
		r.depth = stack_ptr[DEPTH_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		stack_result_t want;
		stack_result_t got;
		int            errs;
		errs = 0;
		if (!arst_n) begin
			foreach (cells[i])
				cells[i] = '0;
			stack_ptr = 0;
			ret_ptr = '0;
			expected_results.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.status      = status_t'(rsp.status);
				got.print_valid = rsp.print_valid;
				got.print_value = rsp.print_value;
				got.depth       = rsp.depth;
				if (expected_results.size() == 0) begin
					$display("%0t: response beat with no request pending (status %0d depth %0d)",
						$time, got.status, got.depth);
					errs++;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						$display({"%0t: expected status %0d print %0b/%0d depth %0d, ",
							"actual status %0d print %0b/%0d depth %0d"}, $time,
							want.status, want.print_valid, want.print_value, want.depth,
							got.status, got.print_valid, got.print_value, got.depth);
						errs++;
					end
				end
			end
			if (req.valid && req.ready)
				expected_results.push_back(apply_stack_op(req.req_type, req.literal));
			outstanding <= expected_results.size();
			if (errs != 0)
				mismatches <= mismatches + errs;
		end
	end

endmodule

### tb/sv/tb_forth_data_stack_unit_top.sv
module tb_forth_data_stack_unit_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fdsu_pkg::*;

	localparam int LAST_CODE    = (1 << OP_W) - 1;
	localparam int RANDOM_BEATS = 950;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   src_idle_pct = 0;
	int   sink_idle_pct = 0;
	int   useful_requests = 0;
	int   mismatches;
	int   outstanding;

	fdsu_req_if req_ch ();
	fdsu_rsp_if rsp_ch ();

	forth_data_stack_unit_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	fdsu_stack_checker stack_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic offer_request(input logic [OP_W-1:0] code, input cell_t lit);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= code;
		req_ch.literal <= lit;
		do @(posedge clk); while (!req_ch.ready);
		if (code <= OP_RP_STORE)
			useful_requests++;
	endtask

	function automatic cell_t any_literal();
		case ($urandom_range(3))
		0: return cell_t'($urandom_range(8));
		1: return $urandom_range(1) ? cell_t'(32'h7FFF_FFFF) : cell_t'(32'h8000_0000);
		default: return $urandom;
		endcase
	endfunction

	// Some picks and sp! requests are preceded by a push of a small index or
	// pointer, so that most get past the underflow and bad-pointer checks.
	task automatic random_stack_item();
		int    r;
		int    choice;
		cell_t target;
		r = $urandom_range(99);
		if (r < 20) begin
			offer_request(OP_PUSH, any_literal());
		end else if (r < 28) begin
			offer_request(OP_PUSH, cell_t'($urandom_range(6)));
			offer_request(OP_PICK, $urandom);
		end else if (r < 36) begin
			choice = $urandom_range(9);
			if (choice < 7)
				target = $urandom_range(STACK_DEPTH);
			else if (choice < 8)
				target = $urandom_range(2 * STACK_DEPTH, STACK_DEPTH + 1);
			else
				target = any_literal();
			offer_request(OP_PUSH, target);
			offer_request(OP_SP_STORE, $urandom);
		end else if (r < 40) begin
			offer_request(OP_W'($urandom_range(LAST_CODE, OP_RP_STORE + 1)), $urandom);
		end else begin
			offer_request(OP_W'($urandom_range(OP_RP_STORE, OP_DROP)), any_literal());
		end
	endtask

	// The receiver holds off for two long stretches so that the block backs up
	// and stops taking request beats.
	initial begin
		int hold_left;
		int cycle_no;
		hold_left = 0;
		cycle_no = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			cycle_no++;
			if (cycle_no == 300 || cycle_no == 1800)
				hold_left = 150;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int phase_end;
		req_ch.valid <= 1'b0;
		req_ch.req_type <= '0;
		req_ch.literal <= '0;
		src_idle_pct = 11;
		sink_idle_pct = 46;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer_request(OP_DUP, '0);
		offer_request(OP_PICK, '0);
		offer_request(OP_PRINT, '0);
		offer_request(OP_SP_STORE, '0);
		offer_request(OP_RP_FETCH, '0);
		offer_request(OP_SWAP, '0);
		offer_request(OP_PUSH, cell_t'(32'h7FFF_FFFF));
		offer_request(OP_ROT, '0);
		offer_request(OP_PUSH, cell_t'(32'h8000_0000));
		offer_request(OP_ROT, '1);
		offer_request(OP_SWAP, '0);
		offer_request(OP_PUSH, cell_t'(-1));
		offer_request(OP_PICK, '0);
		offer_request(OP_DROP, '0);
		offer_request(OP_PUSH, cell_t'(2));
		offer_request(OP_PICK, '0);
		offer_request(OP_RP_STORE, '0);
		offer_request(OP_PRINT, '0);
		offer_request(OP_PUSH, cell_t'(STACK_DEPTH + 1));
		offer_request(OP_SP_STORE, '0);
		offer_request(OP_PUSH, cell_t'(STACK_DEPTH));
		offer_request(OP_SP_STORE, '0);
		offer_request(OP_PUSH, '1);
		offer_request(OP_PICK, '0);
		offer_request(OP_SP_FETCH, '0);
		offer_request(OP_SP_STORE, '0);
		offer_request(OP_W'(LAST_CODE), '1);

		phase_end = useful_requests + RANDOM_BEATS / 3;
		while (useful_requests < phase_end)
			random_stack_item();

		src_idle_pct = 46;
		sink_idle_pct = 11;
		phase_end = useful_requests + RANDOM_BEATS / 3;
		while (useful_requests < phase_end)
			random_stack_item();

		src_idle_pct = 0;
		sink_idle_pct = 0;
		phase_end = useful_requests + RANDOM_BEATS - 2 * (RANDOM_BEATS / 3);
		while (useful_requests < phase_end)
			random_stack_item();
		req_ch.valid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
src/fdsu_pkg.sv
src/fdsu_req_if.sv
src/fdsu_rsp_if.sv
src/fdsu_ram.sv
src/fdsu_ctrl.sv
src/fdsu_dpath.sv
src/forth_data_stack_unit_top.sv
tb/sv/fdsu_stack_checker.sv
tb/sv/tb_forth_data_stack_unit_top.sv
